// File: rtl/b64c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_pkg: shared types, constants and alphabet functions
// Holds the command word passed from the front end to the back end and the
// base64 alphabet mappings in both directions.
// ----------------------------------------------------------------------------
package b64c_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_RESULTS = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // One accepted item's worth of results, up to four beats.
    typedef struct packed {
        logic [1:0]      count_m1;
        logic [3:0][7:0] bytes;
        logic            has_byte;
        logic            last;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] c;
        if (v inside {[6'd0:6'd25]}) begin
            c = 8'h41 + {2'b00, v};
        end else if (v inside {[6'd26:6'd51]}) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v inside {[6'd52:6'd61]}) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic sextet_t char_to_sextet(input logic [7:0] c);
        sextet_t s;
        s.valid = 1'b1;
        if (c inside {[8'h41:8'h5A]}) begin
            s.value = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.value = 6'd62;
        end else if (c == 8'h2F) begin
            s.value = 6'd63;
        end else begin
            s.valid = 1'b0;
            s.value = 6'd0;
        end
        return s;
    endfunction

endpackage

// File: rtl/b64c_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_queue: command queue between front and back end
// Small register FIFO of result commands; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module b64c_queue #(
    parameter int DEPTH = b64c_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b64c_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop,
    output b64c_pkg::cmd_t  head,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64c_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/b64c_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_front: input acceptance and stream state
// Accepts one item per cycle while the queue has room, updates the bit
// accumulator and makes at most one command of up to four result beats.
// ----------------------------------------------------------------------------
module b64c_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic            cfg_data,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output logic            in_stall,
    input  logic            queue_full,
    output logic            push,
    output b64c_pkg::cmd_t  push_data
);

    logic        direction_reg, direction_next;
    logic [15:0] acc_reg, acc_next;
    logic [3:0]  pend_reg, pend_next;
    logic [1:0]  cmf_reg, cmf_next;
    logic        stopped_reg, stopped_next;

    logic              accept;
    logic              need_push;
    // encode path
    logic [5:0]        s0, s1, flush_s;
    logic [1:0]        nemit;
    logic [3:0]        pend_after;
    logic              do_flush;
    logic [2:0]        nchar;
    logic [1:0]        cm_after;
    logic [1:0]        pads;
    logic [2:0]        ntotal;
    logic [2:0][5:0]   sext;
    // decode path
    b64c_pkg::sextet_t dv;
    logic [7:0]        dec_byte;
    logic              dec_got;
    logic [3:0]        dec_pend;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept && need_push;

    // Encode: pending bits are always 0, 2 or 4 before a byte arrives.
    always_comb
    begin
        s1         = in_byte[5:0];
        nemit      = 2'd1;
        case (pend_reg)
            4'd2:
            begin
                s0         = {acc_reg[1:0], in_byte[7:4]};
                pend_after = 4'd4;
            end
            4'd4:
            begin
                s0         = {acc_reg[3:0], in_byte[7:6]};
                nemit      = 2'd2;
                pend_after = 4'd0;
            end
            default:
            begin
                s0         = in_byte[7:2];
                pend_after = 4'd2;
            end
        endcase
        flush_s  = (pend_after == 4'd4) ? {in_byte[3:0], 2'b00} : {in_byte[1:0], 4'b0000};
        do_flush = in_last && (pend_after != 4'd0);
        nchar    = {1'b0, nemit} + {2'b00, do_flush};
        cm_after = cmf_reg + nchar[1:0];
        pads     = in_last ? (2'd0 - cm_after) : 2'd0;
        ntotal   = nchar + {1'b0, pads};
        if (ntotal > 3'd4)
        begin
            ntotal = 3'd4;
        end
        sext[0] = s0;
        sext[1] = (nemit == 2'd2) ? s1 : flush_s;
        sext[2] = flush_s;
    end

    // Decode: unless stopped, a valid character with pending bits ends a byte.
    always_comb
    begin
        dv       = b64c_pkg::char_to_sextet(in_byte);
        dec_got  = 1'b1;
        case (pend_reg)
            4'd2:
            begin
                dec_byte = {acc_reg[1:0], dv.value};
                dec_pend = 4'd0;
            end
            4'd4:
            begin
                dec_byte = {acc_reg[3:0], dv.value[5:2]};
                dec_pend = 4'd2;
            end
            4'd6:
            begin
                dec_byte = {acc_reg[5:0], dv.value[5:4]};
                dec_pend = 4'd4;
            end
            default:
            begin
                dec_byte = 8'd0;
                dec_got  = 1'b0;
                dec_pend = 4'd6;
            end
        endcase
        if (stopped_reg || !dv.valid)
        begin
            dec_got = 1'b0;
        end
    end

    always_comb
    begin
        direction_next = direction_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        cmf_next       = cmf_reg;
        stopped_next   = stopped_reg;
        need_push      = 1'b0;
        push_data      = '0;

        if (direction_reg == b64c_pkg::DIR_ENCODE)
        begin
            need_push          = 1'b1;
            push_data.has_byte = 1'b1;
            push_data.last     = in_last;
            push_data.count_m1 = in_last ? 2'(ntotal - 3'd1) : 2'(nemit - 2'd1);
            for (int i = 0; i < b64c_pkg::MAX_RESULTS; i++)
            begin
                if (i < 3 && 3'(i) < nchar)
                begin
                    push_data.bytes[i] = b64c_pkg::sextet_to_char(sext[i % 3]);
                end else
                begin
                    push_data.bytes[i] = b64c_pkg::PAD_CHAR;
                end
            end
            acc_next  = {acc_reg[7:0], in_byte};
            pend_next = pend_after;
            cmf_next  = cmf_reg + nemit;
        end else
        begin
            need_push          = dec_got || in_last;
            push_data.has_byte = dec_got;
            push_data.last     = in_last;
            push_data.count_m1 = 2'd0;
            push_data.bytes[0] = dec_got ? dec_byte : 8'd0;
            if (!stopped_reg)
            begin
                if (!dv.valid)
                begin
                    stopped_next = 1'b1;
                end else
                begin
                    acc_next  = {acc_reg[9:0], dv.value};
                    pend_next = dec_pend;
                end
            end
        end

        if (!accept)
        begin
            acc_next     = acc_reg;
            pend_next    = pend_reg;
            cmf_next     = cmf_reg;
            stopped_next = stopped_reg;
        end else if (in_last)
        begin
            acc_next     = '0;
            pend_next    = '0;
            cmf_next     = '0;
            stopped_next = 1'b0;
        end

        // A register write restarts the message in the selected direction.
        if (cfg_valid)
        begin
            direction_next = cfg_data;
            acc_next       = '0;
            pend_next      = '0;
            cmf_next       = '0;
            stopped_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= b64c_pkg::DIR_ENCODE;
            acc_reg       <= '0;
            pend_reg      <= '0;
            cmf_reg       <= '0;
            stopped_reg   <= 1'b0;
        end else
        begin
            direction_reg <= direction_next;
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            cmf_reg       <= cmf_next;
            stopped_reg   <= stopped_next;
        end
    end

endmodule

// File: rtl/b64c_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_back: result serializer and output register
// Moves the head command one beat per unstalled cycle into an output register.
// ----------------------------------------------------------------------------
module b64c_back (
    input  logic            clk,
    input  logic            rst_n,
    input  b64c_pkg::cmd_t  head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            out_last
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       has_reg, has_next;
    logic       last_reg, last_next;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       final_beat;

    assign load       = !valid_reg || !out_stall;
    assign final_beat = (idx_reg == head.count_m1);
    assign pop        = load && !empty && final_beat;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign has_byte  = has_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        has_next   = has_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                byte_next = head.bytes[idx_reg];
                has_next  = head.has_byte;
                last_next = head.last && final_beat;
                idx_next  = final_beat ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        has_reg  <= has_next;
        last_reg <= last_next;
    end

endmodule

// File: rtl/base64_stream_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec: streaming base64 encoder and decoder
// Standard alphabet with '=' padding; a one-bit register selects direction.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one byte or character per
// beat, with in_last on the final beat of a message. The output channel
// (out_valid, out_stall) returns characters or decoded bytes; has_byte is low
// only on a bare end marker that closes a decode message with no byte.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the
// direction: 0 encodes, 1 decodes. Every write restarts the message. The user
// must write it only while the codec is idle; the block does not enforce it.
// cfg_ready is always high. Results pass through the command queue, then the
// output register. The front end takes one beat per cycle while the queue has
// room; the back end sends one result beat per cycle while unstalled, so an
// encoded byte that yields two characters, or a last byte that yields up to
// four, goes out as successive beats. The queue depth sets how far the front
// end can run ahead. When the receiver stalls, the output register holds its
// beat, the queue fills and in_stall rises. Reset selects encode, empties the
// queue and clears the accumulator; no clearing pass is needed.
// ----------------------------------------------------------------------------
module base64_stream_codec #(
    parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last
);

    b64c_pkg::cmd_t push_data;
    b64c_pkg::cmd_t head;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    // Configuration writes must only arrive while idle; this is not enforced.
    assign cfg_ready = 1'b1;

    // The front end owns the stream state and builds up to one command per item.
    b64c_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .in_stall   (in_stall),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // The queue lets the input keep flowing while a multi-beat result drains.
    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    // The back end sends the head command out one beat at a time.
    b64c_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (queue_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .out_last  (out_last)
    );

endmodule
